// ===== design/mpcb_pkg.sv =====
// ----------------------------------------------------------------------------
// Multiphase PWM current balancer package
// Shared types and constants for the balancer lanes, merge and error units.
// ----------------------------------------------------------------------------
package mpcb_pkg;

  // Number of interleaved phases, one lane each.
  localparam int PHASES = 4;
  localparam int IDX_W  = $clog2(PHASES);

  // Field widths of the stream words.
  localparam int CUR_W  = 16;
  localparam int MAG_W  = CUR_W + 1;
  localparam int SUM_W  = MAG_W + IDX_W;
  localparam int REG_W  = 16;
  localparam int THR_W  = 15;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W = 3;

  // Reset value of the max_compare register.
  localparam logic [REG_W-1:0] MAX_COMPARE_RESET = 16'd4095;

  // Item kinds carried in tuser.
  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_STOP   = 2'd1,
    KIND_RESET  = 2'd2
  } kind_e;

  // Regulation modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_CURRENT = 2'd0,
    MODE_VOLTAGE = 2'd1,
    MODE_POWER   = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONTROL_MODE      = 3'd0,
    CFG_NOMINAL_CURRENT   = 3'd1,
    CFG_NOMINAL_VOLTAGE   = 3'd2,
    CFG_BALANCE_THRESHOLD = 3'd3,
    CFG_MAX_COMPARE       = 3'd4
  } cfg_idx_e;

  typedef logic signed [CUR_W-1:0] cur_t;
  typedef logic [MAG_W-1:0]        mag_t;

  // Sign of the regulation error.
  typedef struct packed {
    logic pos;
    logic neg;
  } err_t;

  // Update command sent to one lane.
  typedef struct packed {
    kind_e kind;
    logic  bal;
    logic  dec;
    logic  inc;
  } lane_cmd_t;

endpackage

// ===== design/mpcb_lane.sv =====
// ----------------------------------------------------------------------------
// Balancer phase lane
// Holds the compare value of one phase, applies the update command and
// reports the magnitude of the phase current to the merge stage.
// ----------------------------------------------------------------------------
module mpcb_lane import mpcb_pkg::*; #(
  parameter int COMPARE_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cur_t                    cur_i,
  output mag_t                    mag_o,
  input  logic [COMPARE_BITS-1:0] lim_i,
  input  logic                    load_i,
  input  lane_cmd_t               cmd_i,
  output logic [COMPARE_BITS-1:0] value_o,
  output logic                    stop_o
);

  localparam logic [REG_W-1:0] MASK = REG_W'((1 << COMPARE_BITS) - 1);
  localparam logic [COMPARE_BITS-1:0] RESET_LIM =
    (MAX_COMPARE_RESET > MASK) ? COMPARE_BITS'(MASK) : COMPARE_BITS'(MAX_COMPARE_RESET);

  logic signed [MAG_W-1:0]  cur_x;
  logic [COMPARE_BITS-1:0]  value_q, value_d, next_v, dec_v, inc_v;
  logic [COMPARE_BITS:0]    inc_n;

  // Magnitude of the phase current; the most negative value fits in 17 bits.
  assign cur_x = {cur_i[CUR_W-1], cur_i};
  assign mag_o = cur_x[MAG_W-1] ? MAG_W'(-cur_x) : MAG_W'(cur_x);

  // Floored decrement and clipped increment of the stored value.
  assign dec_v = (value_q <= COMPARE_BITS'(1)) ? '0 : value_q - COMPARE_BITS'(1);
  assign inc_n = (COMPARE_BITS+1)'(value_q) + (COMPARE_BITS+1)'(1);
  assign inc_v = (inc_n >= (COMPARE_BITS+1)'(lim_i)) ? lim_i : inc_n[COMPARE_BITS-1:0];

  // New value for the command of the item.
  always_comb begin
    next_v = value_q;
    unique case (cmd_i.kind)
      KIND_UPDATE: begin
        if (cmd_i.bal) begin
          if (cmd_i.dec) begin
            next_v = dec_v;
          end else if (cmd_i.inc) begin
            next_v = inc_v;
          end
        end else if (value_q > COMPARE_BITS'(1)) begin
          next_v = value_q - COMPARE_BITS'(1);
        end
      end
      KIND_STOP: begin
        if (value_q < lim_i) begin
          next_v = value_q + COMPARE_BITS'(1);
        end
      end
      KIND_RESET: begin
        next_v = lim_i;
      end
      default: begin
        next_v = value_q;
      end
    endcase
  end

  assign value_d = load_i ? next_v : value_q;
  assign stop_o  = (next_v == lim_i);
  assign value_o = value_q;

  // Compare value storage; it also serves as the output word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= RESET_LIM;
    end else begin
      value_q <= value_d;
    end
  end

endmodule

// ===== design/mpcb_merge.sv =====
// ----------------------------------------------------------------------------
// Balancer lane merge
// Sums the lane magnitudes against the threshold and picks the phases with
// the lowest and highest current, lowest index first on a tie.
// ----------------------------------------------------------------------------
module mpcb_merge import mpcb_pkg::*; (
  input  cur_t               cur_i [PHASES],
  input  mag_t               mag_i [PHASES],
  input  logic [THR_W-1:0]   thr_i,
  output logic               bal_o,
  output logic [IDX_W-1:0]   lo_o,
  output logic [IDX_W-1:0]   hi_o
);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] thr4;

  // Total magnitude compared with four times the threshold.
  always_comb begin
    sum = '0;
    for (int i = 0; i < PHASES; i++) begin
      sum = sum + SUM_W'(mag_i[i]);
    end
  end

  assign thr4  = SUM_W'({thr_i, 2'b00});
  assign bal_o = (sum >= thr4);

  // Running minimum and maximum; strict compares keep the lowest index.
  always_comb begin
    lo_o = '0;
    hi_o = '0;
    for (int i = 1; i < PHASES; i++) begin
      if (cur_i[i] > cur_i[hi_o]) begin
        hi_o = IDX_W'(i);
      end
      if (cur_i[i] < cur_i[lo_o]) begin
        lo_o = IDX_W'(i);
      end
    end
  end

endmodule

// ===== design/mpcb_err.sv =====
// ----------------------------------------------------------------------------
// Balancer error sign unit
// Forms the regulation error exactly over two stages (product, then
// subtract) and keeps only its sign.
// ----------------------------------------------------------------------------
module mpcb_err import mpcb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s1_en_i,
  input  logic              s2_en_i,
  input  mode_e             mode_i,
  input  logic [REG_W-1:0]  nom_cur_i,
  input  logic [REG_W-1:0]  nom_volt_i,
  input  cur_t              avg_i,
  input  logic [REG_W-1:0]  volt_i,
  output err_t              err_o
);

  logic [2*REG_W-1:0]         nom_prod_q;
  logic signed [33:0]         prod_d, prod_q;
  cur_t                       avg_q;
  logic signed [35:0]         diff_pw;
  logic signed [CUR_W+2:0]    diff_cu;
  logic                       power;
  err_t                       err_d, err_q;

  // Nominal power product; the user must keep configuration static while items flow, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nom_prod_q <= '0;
    end else begin
      nom_prod_q <= nom_cur_i * nom_volt_i;
    end
  end

  // Stage one: measured power product.
  assign prod_d = $signed({avg_i[CUR_W-1], avg_i}) * $signed({1'b0, volt_i});

  always_ff @(posedge clk_i) begin
    if (s1_en_i) begin
      prod_q <= prod_d;
      avg_q  <= avg_i;
    end
  end

  // Stage two: exact error and its sign.
  assign power   = !(mode_i == MODE_CURRENT || mode_i == MODE_VOLTAGE);
  assign diff_pw = $signed({4'b0000, nom_prod_q}) - $signed({prod_q, 2'b00});
  assign diff_cu = $signed({3'b000, nom_cur_i}) - $signed({avg_q[CUR_W-1], avg_q, 2'b00});

  always_comb begin
    if (power) begin
      err_d.neg = diff_pw[35];
      err_d.pos = !diff_pw[35] && (diff_pw != '0);
    end else begin
      err_d.neg = diff_cu[CUR_W+2];
      err_d.pos = !diff_cu[CUR_W+2] && (diff_cu != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en_i) begin
      err_q <= err_d;
    end
  end

  assign err_o = err_q;

endmodule

// ===== design/multiphase_pwm_current_balancer.sv =====
// ----------------------------------------------------------------------------
// Multiphase PWM current balancer
// Keeps the four PWM compare values of an interleaved converter and nudges
// them from phase current measurements, with soft start and soft stop.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the output side is ready and
// returns one word for each word taken. The first stage forms the
// measured power product and the lane min/max/threshold decision, the
// second subtracts to get the error sign, and the third updates the four
// compare registers, which are also the output word. The compare registers
// feed back into their own next value, so back-to-back words always see
// the values left by the word before them. A stall on the output side holds
// the pipeline stage by stage; empty stages keep filling. The configuration
// port is always ready; write it only while no word is in flight. The power
// mode nominal product is registered, so one cycle must pass after a write
// before the next word enters.
// ----------------------------------------------------------------------------
module multiphase_pwm_current_balancer import mpcb_pkg::*; #(
  parameter int COMPARE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // phase_current_0, phase_current_1, phase_current_2, phase_current_3,
  // average_current, output_voltage
  input  logic [95:0]          s_axis_tdata,
  // kind
  input  logic [1:0]           s_axis_tuser,
  // Output stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // compare_0, compare_1, compare_2, compare_3
  output logic [63:0]          m_axis_tdata,
  // is_balancing, all_stopped
  output logic [1:0]           m_axis_tuser
);

  localparam logic [REG_W-1:0] MASK = REG_W'((1 << COMPARE_BITS) - 1);

  // Configuration registers.
  mode_e             mode_q;
  logic [REG_W-1:0]  nom_cur_q, nom_volt_q, max_q;
  logic [THR_W-1:0]  thr_q;
  logic              cfg_we;

  // Pipeline control.
  logic s1_v_q, s2_v_q, out_v_q;
  logic s1_rdy, s2_rdy, out_rdy;
  logic s1_en, s2_en, load;

  // Pipeline payload.
  kind_e             in_kind;
  kind_e             s1_kind_q, s2_kind_q;
  logic              s1_bal_q, s2_bal_q;
  logic [IDX_W-1:0]  s1_lo_q, s1_hi_q, s2_lo_q, s2_hi_q;
  logic              balancing_q, stopped_q;

  // Lane signals.
  cur_t                     cur [PHASES];
  mag_t                     mag [PHASES];
  logic                     m_bal;
  logic [IDX_W-1:0]         m_lo, m_hi;
  err_t                     err;
  logic [COMPARE_BITS-1:0]  lim;
  logic [COMPARE_BITS-1:0]  value [PHASES];
  logic [PHASES-1:0]        stop, dec_sel, inc_sel;
  lane_cmd_t                cmd [PHASES];

  // Configuration writes.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_CURRENT;
      nom_cur_q  <= '0;
      nom_volt_q <= '0;
      thr_q      <= '0;
      max_q      <= MAX_COMPARE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_CONTROL_MODE:      mode_q     <= mode_e'(cfg_data_i[MODE_W-1:0]);
        CFG_NOMINAL_CURRENT:   nom_cur_q  <= cfg_data_i;
        CFG_NOMINAL_VOLTAGE:   nom_volt_q <= cfg_data_i;
        CFG_BALANCE_THRESHOLD: thr_q      <= cfg_data_i[THR_W-1:0];
        CFG_MAX_COMPARE:       max_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Limit clipped to the compare width.
  assign lim = (max_q > MASK) ? COMPARE_BITS'(MASK) : max_q[COMPARE_BITS-1:0];

  // Stage handshakes; each stage moves when the one after it has room.
  assign out_rdy = !out_v_q || m_axis_tready;
  assign s2_rdy  = !s2_v_q || out_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;
  assign s1_en   = s_axis_tvalid && s1_rdy;
  assign s2_en   = s1_v_q && s2_rdy;
  assign load    = s2_v_q && out_rdy;

  assign s_axis_tready = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= s_axis_tvalid;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (out_rdy) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // Input fields.
  assign in_kind = kind_e'(s_axis_tuser);
  for (genvar g = 0; g < PHASES; g++) begin : g_cur
    assign cur[g] = s_axis_tdata[g*CUR_W +: CUR_W];
  end

  // Merge of the lane measurements.
  mpcb_merge u_merge (
    .cur_i (cur),
    .mag_i (mag),
    .thr_i (thr_q),
    .bal_o (m_bal),
    .lo_o  (m_lo),
    .hi_o  (m_hi)
  );

  // Regulation error sign.
  mpcb_err u_err (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_en_i    (s1_en),
    .s2_en_i    (s2_en),
    .mode_i     (mode_q),
    .nom_cur_i  (nom_cur_q),
    .nom_volt_i (nom_volt_q),
    .avg_i      (s_axis_tdata[PHASES*CUR_W +: CUR_W]),
    .volt_i     (s_axis_tdata[(PHASES+1)*CUR_W +: REG_W]),
    .err_o      (err)
  );

  // Decision registers for stages one and two.
  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_kind_q <= in_kind;
      s1_bal_q  <= m_bal;
      s1_lo_q   <= m_lo;
      s1_hi_q   <= m_hi;
    end
    if (s2_en) begin
      s2_kind_q <= s1_kind_q;
      s2_bal_q  <= s1_bal_q;
      s2_lo_q   <= s1_lo_q;
      s2_hi_q   <= s1_hi_q;
    end
  end

  // Phase lanes.
  for (genvar g = 0; g < PHASES; g++) begin : g_lane
    assign dec_sel[g]  = s2_bal_q && err.pos && (s2_lo_q == IDX_W'(g));
    assign inc_sel[g]  = s2_bal_q && err.neg && (s2_hi_q == IDX_W'(g));
    assign cmd[g].kind = s2_kind_q;
    assign cmd[g].bal  = s2_bal_q;
    assign cmd[g].dec  = dec_sel[g];
    assign cmd[g].inc  = inc_sel[g];

    mpcb_lane #(
      .COMPARE_BITS (COMPARE_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cur_i   (cur[g]),
      .mag_o   (mag[g]),
      .lim_i   (lim),
      .load_i  (load),
      .cmd_i   (cmd[g]),
      .value_o (value[g]),
      .stop_o  (stop[g])
    );

    assign m_axis_tdata[g*REG_W +: REG_W] = REG_W'(value[g]);
  end

  // Output flags, loaded with the compare values.
  always_ff @(posedge clk_i) begin
    if (load) begin
      balancing_q <= (s2_kind_q == KIND_UPDATE) && s2_bal_q;
      stopped_q   <= &stop;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = {stopped_q, balancing_q};

  // A reset word always reports every phase stopped.
  a_reset_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && (s2_kind_q == KIND_RESET) |=> m_axis_tuser[1])
    else $error("reset word did not report all phases stopped");

  // Only a control update can report balancing.
  a_bal_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && (s2_kind_q != KIND_UPDATE) |=> !m_axis_tuser[0])
    else $error("balancing flagged on a non-update word");

  // At most one lane is nudged per word.
  a_one_lane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({dec_sel, inc_sel}))
    else $error("more than one lane selected for a nudge");

  // Input back-pressure only with every stage full.
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_v_q && s2_v_q && out_v_q)
    else $error("input stalled with a free pipeline stage");

endmodule
